// ===== design/dtp_pkg.sv =====
package dtp_pkg;

    localparam int CHAR_W     = 8;
    localparam int MANT_W     = 60;
    localparam int COUNT_W    = 8;
    localparam int MAX_DIGITS = 18;
    localparam int MAX_CHARS  = 255;
    localparam int EXT_W      = MANT_W + 4;

    localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_POINT = 8'h2E;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;

    localparam logic [COUNT_W-1:0] COUNT_SAT = {COUNT_W{1'b1}};

    // Largest mantissa: MAX_DIGITS nines, limited to the mantissa width.
    function automatic logic [MANT_W-1:0] mant_cap_f();
        logic [EXT_W-1:0] v;
        logic             hit;
        v   = '0;
        hit = 1'b0;
        for (int i = 0; i < 19; i++) begin
            if (i < MAX_DIGITS && !hit) begin
                v = v * EXT_W'(10) + EXT_W'(9);
                if (v > {{(EXT_W-MANT_W){1'b0}}, {MANT_W{1'b1}}}) begin
                    hit = 1'b1;
                end
            end
        end
        if (hit) begin
            return {MANT_W{1'b1}};
        end
        return v[MANT_W-1:0];
    endfunction

    localparam logic [MANT_W-1:0] MANT_CAP = mant_cap_f();

    localparam logic [COUNT_W-1:0] CHAR_LIMIT =
        (MAX_CHARS > 255) ? COUNT_SAT : COUNT_W'(MAX_CHARS);

    typedef enum logic [0:0] {
        PH_SKIP = 1'b0,
        PH_BODY = 1'b1
    } phase_t;

    typedef struct packed {
        phase_t               phase;
        logic                 sign_seen;
        logic [MANT_W-1:0]    acc;
        logic [COUNT_W-1:0]   digit_count;
        logic [COUNT_W-1:0]   point_pos;
        logic                 point_seen;
        logic [COUNT_W-1:0]   char_count;
        logic                 overflow_seen;
    } parse_state_t;

    typedef struct packed {
        logic                 valid_res;
        logic                 negative;
        logic [MANT_W-1:0]    mantissa;
        logic [COUNT_W-1:0]   fraction_digits;
        logic [COUNT_W-1:0]   consumed;
        logic                 overflow;
    } result_t;

endpackage

// ===== design/dtp_input_stage.sv =====
module dtp_input_stage (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [dtp_pkg::CHAR_W-1:0]    s_character,
    input  logic                          advance,
    output logic                          char_valid,
    output logic [dtp_pkg::CHAR_W-1:0]    char_data
);

    logic                       valid_reg;
    logic                       valid_next;
    logic [dtp_pkg::CHAR_W-1:0] char_reg;

    assign s_ready = !valid_reg || advance;

    always_comb begin
        valid_next = valid_reg;
        if (s_valid && s_ready) begin
            valid_next = 1'b1;
        end else if (advance) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            char_reg <= s_character;
        end
    end

    assign char_valid = valid_reg;
    assign char_data  = char_reg;

endmodule

// ===== design/dtp_parse_core.sv =====
module dtp_parse_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    input  logic                          cfg_data,
    input  logic                          advance,
    input  logic [dtp_pkg::CHAR_W-1:0]    char_data,
    output logic                          emit,
    output dtp_pkg::result_t              result
);

    dtp_pkg::parse_state_t st_reg;
    dtp_pkg::parse_state_t st_next;
    logic                  fraction_mode_reg;

    logic                        is_digit;
    logic                        is_space;
    logic                        to_body;
    logic                        take_digit;
    logic                        take_point;
    logic [dtp_pkg::CHAR_W-1:0]  digit;
    logic [dtp_pkg::EXT_W-1:0]   acc_ext;
    logic [dtp_pkg::EXT_W-1:0]   acc_times_ten;
    logic [dtp_pkg::COUNT_W-1:0] digit_count_inc;
    logic [dtp_pkg::COUNT_W-1:0] char_count_inc;
    logic [dtp_pkg::COUNT_W-1:0] point_pos_inc;

    assign is_digit = (char_data >= dtp_pkg::CHAR_ZERO) && (char_data <= dtp_pkg::CHAR_NINE);
    assign is_space = ((char_data >= dtp_pkg::CHAR_TAB) && (char_data <= dtp_pkg::CHAR_CR))
                      || (char_data == dtp_pkg::CHAR_SPACE);
    assign digit    = char_data - dtp_pkg::CHAR_ZERO;

    assign acc_ext       = {{(dtp_pkg::EXT_W-dtp_pkg::MANT_W){1'b0}}, st_reg.acc};
    assign acc_times_ten = (acc_ext << 3) + (acc_ext << 1)
                           + {{(dtp_pkg::EXT_W-4){1'b0}}, digit[3:0]};

    assign digit_count_inc = (st_reg.digit_count == dtp_pkg::COUNT_SAT)
                             ? st_reg.digit_count : st_reg.digit_count + 1'b1;
    assign char_count_inc  = (st_reg.char_count >= dtp_pkg::CHAR_LIMIT)
                             ? st_reg.char_count : st_reg.char_count + 1'b1;
    assign point_pos_inc   = (st_reg.point_pos == dtp_pkg::COUNT_SAT)
                             ? st_reg.point_pos : st_reg.point_pos + 1'b1;

    always_comb begin
        st_next    = st_reg;
        emit       = 1'b0;
        to_body    = 1'b0;
        take_digit = 1'b0;
        take_point = 1'b0;

        if (st_reg.phase == dtp_pkg::PH_BODY) begin
            to_body = 1'b1;
        end else if (char_data == dtp_pkg::CHAR_NUL) begin
            emit = 1'b1;
        end else if (is_space) begin
            st_next.char_count = char_count_inc;
        end else if (char_data == dtp_pkg::CHAR_MINUS) begin
            st_next.sign_seen  = 1'b1;
            st_next.phase      = dtp_pkg::PH_BODY;
            st_next.char_count = char_count_inc;
        end else begin
            to_body = 1'b1;
        end

        if (to_body) begin
            st_next.phase = dtp_pkg::PH_BODY;
            if (is_digit) begin
                take_digit = 1'b1;
            end else if (fraction_mode_reg && (char_data == dtp_pkg::CHAR_POINT)) begin
                take_point = 1'b1;
            end else begin
                emit = 1'b1;
            end
        end

        if (take_digit) begin
            st_next.digit_count = digit_count_inc;
            if (!st_reg.overflow_seen) begin
                if ((digit_count_inc > dtp_pkg::COUNT_W'(dtp_pkg::MAX_DIGITS))
                    || (acc_times_ten > {{(dtp_pkg::EXT_W-dtp_pkg::MANT_W){1'b0}},
                                         dtp_pkg::MANT_CAP})) begin
                    st_next.overflow_seen = 1'b1;
                    st_next.acc           = dtp_pkg::MANT_CAP;
                end else begin
                    st_next.acc = acc_times_ten[dtp_pkg::MANT_W-1:0];
                end
            end
            if (st_reg.point_seen) begin
                st_next.point_pos = point_pos_inc;
            end
            st_next.char_count = char_count_inc;
        end

        if (take_point) begin
            st_next.point_seen = 1'b1;
            st_next.point_pos  = '0;
            st_next.char_count = char_count_inc;
        end

        if (emit) begin
            st_next = '0;
        end
    end

    always_comb begin
        result = '0;
        if (st_reg.digit_count != '0) begin
            result.valid_res       = 1'b1;
            result.negative        = st_reg.sign_seen;
            result.mantissa        = st_reg.acc;
            result.fraction_digits = st_reg.point_seen ? st_reg.point_pos : '0;
            result.consumed        = st_reg.char_count;
            result.overflow        = st_reg.overflow_seen;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg            <= '0;
            fraction_mode_reg <= 1'b1;
        end else begin
            if (advance) begin
                st_reg <= st_next;
            end
            if (cfg_valid) begin
                fraction_mode_reg <= cfg_data;
            end
        end
    end

    a_mant_capped: assert property (@(posedge aclk) disable iff (!aresetn)
        st_reg.acc <= dtp_pkg::MANT_CAP)
        else $error("Mantissa above its cap.");

    a_ovf_holds_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        st_reg.overflow_seen |-> (st_reg.acc == dtp_pkg::MANT_CAP))
        else $error("Overflow without saturated mantissa.");

    a_point_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg.point_pos != '0) |-> st_reg.point_seen)
        else $error("Fraction count without a decimal point.");

    a_skip_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg.phase == dtp_pkg::PH_SKIP) |->
            ((st_reg.digit_count == '0) && !st_reg.point_seen && !st_reg.sign_seen))
        else $error("Number state present in the whitespace phase.");

    a_emit_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && emit) |=> (st_reg == '0))
        else $error("State not cleared after a result.");

endmodule

// ===== design/dtp_result_stage.sv =====
module dtp_result_stage (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          load,
    input  dtp_pkg::result_t              result,
    output logic                          m_valid,
    input  logic                          m_ready,
    output dtp_pkg::result_t              m_result
);

    logic             valid_reg;
    logic             valid_next;
    dtp_pkg::result_t result_reg;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            result_reg <= result;
        end
    end

    assign m_valid  = valid_reg;
    assign m_result = result_reg;

endmodule

// ===== design/decimal_text_number_parser.sv =====
// A result is registered after its ending character leaves the input register.
// Throughput: one character per cycle while the result side takes each result at once.
// A waiting result holds up only the character that ends the next number.
// Reset (aresetn low at a clock edge) empties both stages, clears the parse state
// and sets fraction_mode to 1.
module decimal_text_number_parser (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic                              cfg_data,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [dtp_pkg::CHAR_W-1:0]        s_character,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_valid_res,
    output logic                              m_negative,
    output logic [dtp_pkg::MANT_W-1:0]        m_mantissa,
    output logic [dtp_pkg::COUNT_W-1:0]       m_fraction_digits,
    output logic [dtp_pkg::COUNT_W-1:0]       m_consumed,
    output logic                              m_overflow
);

    logic                       char_valid;
    logic [dtp_pkg::CHAR_W-1:0] char_data;
    logic                       advance;
    logic                       emit;
    dtp_pkg::result_t           result;
    dtp_pkg::result_t           m_result;

    assign cfg_ready = 1'b1;
    assign advance   = char_valid && (!emit || !m_valid || m_ready);

    dtp_input_stage u_input (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_character (s_character),
        .advance     (advance),
        .char_valid  (char_valid),
        .char_data   (char_data)
    );

    dtp_parse_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .advance   (advance),
        .char_data (char_data),
        .emit      (emit),
        .result    (result)
    );

    dtp_result_stage u_result (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (advance && emit),
        .result   (result),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_result (m_result)
    );

    assign m_valid_res       = m_result.valid_res;
    assign m_negative        = m_result.negative;
    assign m_mantissa        = m_result.mantissa;
    assign m_fraction_digits = m_result.fraction_digits;
    assign m_consumed        = m_result.consumed;
    assign m_overflow        = m_result.overflow;

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps

module tb;

    localparam logic [dtp_pkg::MANT_W-1:0] MANT_LIMIT  = 60'd999_999_999_999_999_999;
    localparam int                         CYCLE_LIMIT = 400000;
    localparam int                         NUM_PHASES  = 4;
    localparam int                         PHASE_ITEMS = 475;

    logic                         aclk = 1'b0;
    logic                         aresetn = 1'b0;
    logic                         cfg_valid = 1'b0;
    logic                         cfg_ready;
    logic                         cfg_data = 1'b0;
    logic                         s_valid = 1'b0;
    logic                         s_ready;
    logic [dtp_pkg::CHAR_W-1:0]   s_character = '0;
    logic                         m_valid;
    logic                         m_ready = 1'b0;
    logic                         m_valid_res;
    logic                         m_negative;
    logic [dtp_pkg::MANT_W-1:0]   m_mantissa;
    logic [dtp_pkg::COUNT_W-1:0]  m_fraction_digits;
    logic [dtp_pkg::COUNT_W-1:0]  m_consumed;
    logic                         m_overflow;

    decimal_text_number_parser dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_data          (cfg_data),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_character       (s_character),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_valid_res       (m_valid_res),
        .m_negative        (m_negative),
        .m_mantissa        (m_mantissa),
        .m_fraction_digits (m_fraction_digits),
        .m_consumed        (m_consumed),
        .m_overflow        (m_overflow)
    );

    logic [dtp_pkg::CHAR_W-1:0] pending_chars[$];
    dtp_pkg::result_t           expected_numbers[$];

    int  chars_queued = 0;
    int  chars_sent   = 0;
    int  errors       = 0;
    int  cycle_count  = 0;
    int  send_gap     = 0;
    int  recv_stall   = 0;
    bit  idle_on      = 1'b1;

    // Parser state as the block should hold it.
    logic                        frac_mode = 1'b1;
    dtp_pkg::phase_t             num_phase = dtp_pkg::PH_SKIP;
    logic                        neg       = 1'b0;
    logic [dtp_pkg::MANT_W-1:0]  acc       = '0;
    logic [dtp_pkg::COUNT_W-1:0] dig_count = '0;
    logic [dtp_pkg::COUNT_W-1:0] pt_pos    = '0;
    logic                        pt_seen   = 1'b0;
    logic [dtp_pkg::COUNT_W-1:0] chars     = '0;
    logic                        ovf       = 1'b0;

    initial begin
        forever #5 aclk = ~aclk;
    end

    task automatic bump_chars();
        if (chars != dtp_pkg::CHAR_LIMIT) begin
            chars++;
        end
    endtask

    task automatic finish_number();
        dtp_pkg::result_t r;
        r = '0;
        if (dig_count != 0) begin
            r.valid_res       = 1'b1;
            r.negative        = neg;
            r.mantissa        = acc;
            r.fraction_digits = pt_seen ? pt_pos : '0;
            r.consumed        = chars;
            r.overflow        = ovf;
        end
        expected_numbers.push_back(r);
        num_phase = dtp_pkg::PH_SKIP;
        neg       = 1'b0;
        acc       = '0;
        dig_count = '0;
        pt_pos    = '0;
        pt_seen   = 1'b0;
        chars     = '0;
        ovf       = 1'b0;
    endtask

    task automatic parse_char(input logic [dtp_pkg::CHAR_W-1:0] c);
        logic        is_digit;
        logic        is_space;
        logic [63:0] wide;
        is_digit = (c >= dtp_pkg::CHAR_ZERO) && (c <= dtp_pkg::CHAR_NINE);
        is_space = ((c >= dtp_pkg::CHAR_TAB) && (c <= dtp_pkg::CHAR_CR))
                   || (c == dtp_pkg::CHAR_SPACE);
        if (num_phase == dtp_pkg::PH_SKIP && c == dtp_pkg::CHAR_NUL) begin
            finish_number();
        end else if (num_phase == dtp_pkg::PH_SKIP && is_space) begin
            bump_chars();
        end else if (num_phase == dtp_pkg::PH_SKIP && c == dtp_pkg::CHAR_MINUS) begin
            neg       = 1'b1;
            num_phase = dtp_pkg::PH_BODY;
            bump_chars();
        end else begin
            num_phase = dtp_pkg::PH_BODY;
            if (is_digit) begin
                if (dig_count != dtp_pkg::COUNT_SAT) begin
                    dig_count++;
                end
                if (!ovf) begin
                    wide = {4'b0, acc} * 64'd10 + 64'(c - dtp_pkg::CHAR_ZERO);
                    if (dig_count > dtp_pkg::MAX_DIGITS || wide > {4'b0, MANT_LIMIT}) begin
                        ovf = 1'b1;
                        acc = MANT_LIMIT;
                    end else begin
                        acc = wide[dtp_pkg::MANT_W-1:0];
                    end
                end
                if (pt_seen && pt_pos != dtp_pkg::COUNT_SAT) begin
                    pt_pos++;
                end
                bump_chars();
            end else if (frac_mode && c == dtp_pkg::CHAR_POINT) begin
                pt_seen = 1'b1;
                pt_pos  = '0;
                bump_chars();
            end else begin
                finish_number();
            end
        end
    endtask

    function automatic void check_field(input string name, input logic [63:0] exp_v,
                                        input logic [63:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, exp_v, act_v);
            errors++;
        end
    endfunction

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid  <= 1'b0;
            send_gap = 0;
        end else begin
            if (s_valid && s_ready) begin
                parse_char(s_character);
                chars_sent++;
                send_gap = idle_on ? $urandom_range(0, 9) : 0;
            end
            if (!s_valid || s_ready) begin
                if (send_gap == 0 && pending_chars.size() > 0) begin
                    s_valid     <= 1'b1;
                    s_character <= pending_chars.pop_front();
                end else begin
                    s_valid <= 1'b0;
                    if (send_gap > 0) begin
                        send_gap--;
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        dtp_pkg::result_t exp_r;
        if (!aresetn) begin
            m_ready    <= 1'b0;
            recv_stall = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_numbers.size() == 0) begin
                    $display("%0t: unexpected result transfer: expected none, actual mantissa %0d",
                             $time, m_mantissa);
                    errors++;
                end else begin
                    exp_r = expected_numbers.pop_front();
                    check_field("valid_res", 64'(exp_r.valid_res), 64'(m_valid_res));
                    check_field("negative", 64'(exp_r.negative), 64'(m_negative));
                    check_field("mantissa", 64'(exp_r.mantissa), 64'(m_mantissa));
                    check_field("fraction_digits", 64'(exp_r.fraction_digits),
                                64'(m_fraction_digits));
                    check_field("consumed", 64'(exp_r.consumed), 64'(m_consumed));
                    check_field("overflow", 64'(exp_r.overflow), 64'(m_overflow));
                end
                recv_stall = idle_on ? $urandom_range(0, 9) : 0;
            end
            if (recv_stall > 0) begin
                m_ready <= 1'b0;
                recv_stall--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic add_char(input logic [dtp_pkg::CHAR_W-1:0] c);
        pending_chars.push_back(c);
        chars_queued++;
    endtask

    task automatic add_text(input string text);
        for (int i = 0; i < text.len(); i++) begin
            add_char(text[i]);
        end
    endtask

    task automatic add_space();
        int w;
        w = $urandom_range(0, 5);
        add_char((w == 5) ? dtp_pkg::CHAR_SPACE : dtp_pkg::CHAR_TAB + dtp_pkg::CHAR_W'(w));
    endtask

    task automatic add_number();
        int n_ws;
        int n_dig;
        int r;
        bit long_frac;
        n_ws = ($urandom_range(0, 199) == 0) ? $urandom_range(250, 300) : $urandom_range(0, 3);
        for (int i = 0; i < n_ws; i++) begin
            add_space();
        end
        if ($urandom_range(0, 2) == 0) begin
            add_char(dtp_pkg::CHAR_MINUS);
        end
        r = $urandom_range(0, 99);
        long_frac = (r >= 98);
        n_dig = (r < 5) ? 0 : (r < 85) ? $urandom_range(1, 8) :
                (r < 98) ? $urandom_range(15, 24) : $urandom_range(256, 280);
        if (long_frac) begin
            add_char(dtp_pkg::CHAR_POINT);
        end
        for (int i = 0; i < n_dig; i++) begin
            if (!long_frac && $urandom_range(0, 9) == 0) begin
                add_char(dtp_pkg::CHAR_POINT);
            end
            add_char(dtp_pkg::CHAR_ZERO + dtp_pkg::CHAR_W'($urandom_range(0, 9)));
        end
        if ($urandom_range(0, 3) == 0) begin
            add_char(dtp_pkg::CHAR_POINT);
        end
        case ($urandom_range(0, 4))
            0: add_char(dtp_pkg::CHAR_SPACE);
            1: add_char(dtp_pkg::CHAR_NUL);
            2: add_char(dtp_pkg::CHAR_MINUS);
            3: add_char(dtp_pkg::CHAR_POINT);
            default: add_char(dtp_pkg::CHAR_W'($urandom_range(0, 255)));
        endcase
        if ($urandom_range(0, 9) == 0) begin
            n_ws = $urandom_range(1, 4);
            for (int i = 0; i < n_ws; i++) begin
                add_char(dtp_pkg::CHAR_W'($urandom_range(0, 255)));
            end
        end
    endtask

    task automatic write_mode(input logic mode);
        cfg_valid <= 1'b1;
        cfg_data  <= mode;
        do begin
            @(posedge aclk);
        end while (!cfg_ready);
        frac_mode = mode;
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        while (chars_sent != chars_queued || expected_numbers.size() > 0) begin
            @(posedge aclk);
        end
        repeat (8) @(posedge aclk);
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        write_mode(1'b1);

        // A zero byte while skipping whitespace, a lone point with the last point
        // winning and a second minus as terminator, a trailing point ended by a
        // zero byte, a number with no digit, and a mantissa overflow.
        add_char(dtp_pkg::CHAR_NUL);
        add_text(" -.5.25-");
        add_text("5.");
        add_char(dtp_pkg::CHAR_NUL);
        add_char(8'hFF);
        add_text("9999999999999999999 ");
        drain();

        for (int p = 0; p < NUM_PHASES; p++) begin
            idle_on = (p != 1);
            write_mode(p[0]);
            while (pending_chars.size() < PHASE_ITEMS) begin
                add_number();
            end
            drain();
        end

        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ===== files.f =====
design/dtp_pkg.sv
design/dtp_input_stage.sv
design/dtp_parse_core.sv
design/dtp_result_stage.sv
design/decimal_text_number_parser.sv
dv/tb.sv
